/* rtl/core/cnld_pkg.sv */
package cnld_pkg;

  // Shared divider geometry: dividend holds 100 * 64-bit value, divisor one 64-bit word
  localparam int DIV_NUM_W = 71;
  localparam int DIV_DEN_W = 64;
  localparam int DIV_CNT_W = 7;

  localparam logic [DIV_CNT_W-1:0] STEPS_FULL = 7'd71;
  localparam logic [DIV_CNT_W-1:0] STEPS_WORD = 7'd64;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_LINK_SPEED = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [1:0] CFG_PERIOD     = 2'd2;

  localparam logic [16:0] LINK_SPEED_RST = 17'd1000;
  localparam logic [6:0]  THRESHOLD_RST  = 7'd5;
  localparam logic [7:0]  PERIOD_RST     = 8'd10;

  localparam int LINK_SHIFT = 17;

  localparam logic [6:0] CPU_CAP = 7'd100;
  localparam logic [9:0] NET_CAP = 10'd1000;

  localparam logic signed [7:0]  RPT_RST_CPU = -8'sd100;
  localparam logic signed [10:0] RPT_RST_NET = -11'sd100;

endpackage

/* rtl/core/cnld_div.sv */
module cnld_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cnld_pkg::div_req_t                req,
  input  logic [cnld_pkg::DIV_NUM_W-1:0]    num,
  input  logic [cnld_pkg::DIV_DEN_W-1:0]    den,
  output logic                              done,
  output logic [cnld_pkg::DIV_NUM_W-1:0]    quo
);

  localparam int NW = cnld_pkg::DIV_NUM_W;
  localparam int DW = cnld_pkg::DIV_DEN_W;
  localparam int CW = cnld_pkg::DIV_CNT_W;

  logic                          busy_r;
  logic                          done_r;
  logic [cnld_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [NW-1:0]                 num_r;
  logic [DW-1:0]                 den_r;
  logic [DW-1:0]                 rem_r;
  logic [NW-1:0]                 quo_r;

  logic [DW:0]   rem_shift;
  logic [DW:0]   rem_diff;
  logic          qbit;
  logic [DW-1:0] rem_nxt;

  // Restoring division, one quotient bit a cycle, dividend taken from the top
  assign rem_shift = {rem_r, num_r[NW-1]};
  assign rem_diff  = rem_shift - {1'b0, den_r};
  assign qbit      = (rem_shift >= {1'b0, den_r});
  assign rem_nxt   = qbit ? rem_diff[DW-1:0] : rem_shift[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NW-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/core/cpu_net_load_deadband_monitor.sv */
// CPU and link load monitor. Each accepted word is one sample of cumulative tick and byte
// counters; one result word follows with CPU busy percent and receive/transmit link load
// percent, each with a report flag raised when the value leaves the deadband around the last
// reported value. A sample first sums its TICK_COUNTERS tick counters, then takes up to five
// passes of a shared restoring divider that yields one quotient bit per cycle (71 quotient
// bits for each percent division, 64 for each byte-rate division). in_ready is high only
// between samples; a finished result waits in the output register while the next sample is
// taken. Configuration writes are taken in any cycle and should be made while the block is idle.
module cpu_net_load_deadband_monitor_core #(
  parameter int TICK_COUNTERS = 10
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_ticks_user,
  input  logic [63:0] in_ticks_nice,
  input  logic [63:0] in_ticks_system,
  input  logic [63:0] in_ticks_idle,
  input  logic [63:0] in_ticks_iowait,
  input  logic [63:0] in_ticks_irq,
  input  logic [63:0] in_ticks_softirq,
  input  logic [63:0] in_ticks_steal,
  input  logic [63:0] in_ticks_guest,
  input  logic [63:0] in_ticks_guest_nice,
  input  logic [63:0] in_rx_byte_count,
  input  logic [63:0] in_tx_byte_count,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_cpu_load_pct,
  output logic        out_cpu_report,
  output logic [9:0]  out_rx_load_pct,
  output logic        out_rx_report,
  output logic [9:0]  out_tx_load_pct,
  output logic        out_tx_report,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int CNT_W = (TICK_COUNTERS > 1) ? $clog2(TICK_COUNTERS) : 1;
  localparam int NW    = cnld_pkg::DIV_NUM_W;
  localparam int DW    = cnld_pkg::DIV_DEN_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM      = 4'd1;
  localparam logic [3:0] S_DELTA    = 4'd2;
  localparam logic [3:0] S_BUSY     = 4'd3;
  localparam logic [3:0] S_CPU      = 4'd4;
  localparam logic [3:0] S_CPU_WAIT = 4'd5;
  localparam logic [3:0] S_CPU_DB   = 4'd6;
  localparam logic [3:0] S_RX_GO    = 4'd7;
  localparam logic [3:0] S_RX_Q     = 4'd8;
  localparam logic [3:0] S_RX_P     = 4'd9;
  localparam logic [3:0] S_RX_DB    = 4'd10;
  localparam logic [3:0] S_TX_GO    = 4'd11;
  localparam logic [3:0] S_TX_Q     = 4'd12;
  localparam logic [3:0] S_TX_P     = 4'd13;
  localparam logic [3:0] S_TX_DB    = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  function automatic logic [NW-1:0] mul100(input logic [63:0] a);
    logic [NW-1:0] ax;
    ax = {7'b0, a};
    return (ax << 6) + (ax << 5) + (ax << 2);
  endfunction

  function automatic logic deadband_hit(input logic [9:0] load,
                                        input logic signed [10:0] last,
                                        input logic [6:0] thr);
    logic signed [11:0] diff;
    logic [11:0]        mag;
    diff = $signed({2'b0, load}) - $signed({last[10], last});
    mag  = diff[11] ? 12'(-diff) : 12'(diff);
    return mag > {5'b0, thr};
  endfunction

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [63:0]       tick_r [TICK_COUNTERS];
  logic [63:0]       rx_r, tx_r;
  logic [63:0]       sum_r;
  logic [63:0]       dt_r, di_r, bz_r;

  logic [63:0]       prev_total_r, prev_idle_r, prev_rx_r, prev_tx_r;
  logic [6:0]        held_cpu_r;
  logic [9:0]        held_rx_r, held_tx_r;
  logic signed [7:0] rpt_cpu_r;
  logic signed [10:0] rpt_rx_r, rpt_tx_r;
  logic              cpu_rep_r, rx_rep_r, tx_rep_r;

  logic [16:0]       speed_r;
  logic [6:0]        thr_r;
  logic [7:0]        period_r;

  logic              out_valid_r;
  logic [6:0]        out_cpu_r;
  logic [9:0]        out_rx_r, out_tx_r;
  logic              out_cpu_rep_r, out_rx_rep_r, out_tx_rep_r;

  cnld_pkg::div_req_t div_req;
  logic [NW-1:0]     div_num;
  logic [DW-1:0]     div_den;
  logic              div_done;
  logic [NW-1:0]     div_quo;

  logic [7:0]        period_eff;
  logic [16:0]       speed_eff;
  logic [DW-1:0]     link_den;
  logic [6:0]        cpu_sat;
  logic [9:0]        net_sat;
  logic              in_fire, out_fire;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid_r && out_ready;
  assign cfg_ready  = 1'b1;

  assign period_eff = (period_r == 8'd0) ? 8'd1 : period_r;
  assign speed_eff  = (speed_r == 17'd0) ? 17'd1 : speed_r;
  assign link_den   = {{(DW - 17 - cnld_pkg::LINK_SHIFT){1'b0}}, speed_eff,
                       {cnld_pkg::LINK_SHIFT{1'b0}}};

  assign cpu_sat = (div_quo > {{(NW-7){1'b0}}, cnld_pkg::CPU_CAP}) ? cnld_pkg::CPU_CAP
                                                                  : div_quo[6:0];
  assign net_sat = (div_quo > {{(NW-10){1'b0}}, cnld_pkg::NET_CAP}) ? cnld_pkg::NET_CAP
                                                                   : div_quo[9:0];

  // Sequencer and divider launch
  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.steps = cnld_pkg::STEPS_FULL;
    div_num       = mul100(bz_r);
    div_den       = dt_r;
    unique case (state_r) inside
      S_IDLE: begin
        if (in_fire) state_nxt = S_SUM;
      end
      S_SUM: begin
        if (cnt_r == CNT_W'(TICK_COUNTERS - 1)) state_nxt = S_DELTA;
      end
      S_DELTA: state_nxt = S_BUSY;
      S_BUSY:  state_nxt = S_CPU;
      S_CPU: begin
        if (prev_total_r != 64'd0 && dt_r != 64'd0) begin
          div_req.start = 1'b1;
          state_nxt     = S_CPU_WAIT;
        end else begin
          state_nxt = S_CPU_DB;
        end
      end
      S_CPU_WAIT: begin
        if (div_done) state_nxt = S_CPU_DB;
      end
      S_CPU_DB: state_nxt = S_RX_GO;
      S_RX_GO, S_TX_GO: begin
        if (prev_rx_r != 64'd0) begin
          div_req.start = 1'b1;
          div_req.steps = cnld_pkg::STEPS_WORD;
          div_num       = (state_r == S_RX_GO) ? {rx_r - prev_rx_r, 7'b0}
                                               : {tx_r - prev_tx_r, 7'b0};
          div_den       = {{(DW-8){1'b0}}, period_eff};
          state_nxt     = (state_r == S_RX_GO) ? S_RX_Q : S_TX_Q;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RX_Q, S_TX_Q: begin
        div_num = mul100(div_quo[63:0]);
        div_den = link_den;
        if (div_done) begin
          div_req.start = 1'b1;
          state_nxt     = (state_r == S_RX_Q) ? S_RX_P : S_TX_P;
        end
      end
      S_RX_P: begin
        if (div_done) state_nxt = S_RX_DB;
      end
      S_RX_DB: state_nxt = S_TX_GO;
      S_TX_P: begin
        if (div_done) state_nxt = S_TX_DB;
      end
      S_TX_DB: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  cnld_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      prev_total_r <= '0;
      prev_idle_r  <= '0;
      prev_rx_r    <= '0;
      prev_tx_r    <= '0;
      held_cpu_r   <= '0;
      held_rx_r    <= '0;
      held_tx_r    <= '0;
      rpt_cpu_r    <= cnld_pkg::RPT_RST_CPU;
      rpt_rx_r     <= cnld_pkg::RPT_RST_NET;
      rpt_tx_r     <= cnld_pkg::RPT_RST_NET;
      cpu_rep_r    <= 1'b0;
      rx_rep_r     <= 1'b0;
      tx_rep_r     <= 1'b0;
      speed_r      <= cnld_pkg::LINK_SPEED_RST;
      thr_r        <= cnld_pkg::THRESHOLD_RST;
      period_r     <= cnld_pkg::PERIOD_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cnld_pkg::CFG_LINK_SPEED: speed_r  <= cfg_data;
          cnld_pkg::CFG_THRESHOLD:  thr_r    <= cfg_data[6:0];
          cnld_pkg::CFG_PERIOD:     period_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        cnt_r     <= '0;
        cpu_rep_r <= 1'b0;
        rx_rep_r  <= 1'b0;
        tx_rep_r  <= 1'b0;
      end else if (state_r == S_SUM) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (state_r == S_CPU_WAIT && div_done) held_cpu_r <= cpu_sat;
      if (state_r == S_RX_P && div_done)     held_rx_r  <= net_sat;
      if (state_r == S_TX_P && div_done)     held_tx_r  <= net_sat;

      // Deadband: report and record when the load moves past the threshold
      if (state_r == S_CPU_DB && prev_total_r != 64'd0 &&
          deadband_hit({3'b0, held_cpu_r}, 11'(rpt_cpu_r), thr_r)) begin
        cpu_rep_r <= 1'b1;
        rpt_cpu_r <= $signed({1'b0, held_cpu_r});
      end
      if (state_r == S_RX_DB && deadband_hit(held_rx_r, rpt_rx_r, thr_r)) begin
        rx_rep_r <= 1'b1;
        rpt_rx_r <= $signed({1'b0, held_rx_r});
      end
      if (state_r == S_TX_DB && deadband_hit(held_tx_r, rpt_tx_r, thr_r)) begin
        tx_rep_r <= 1'b1;
        rpt_tx_r <= $signed({1'b0, held_tx_r});
      end

      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r  <= 1'b1;
        prev_total_r <= sum_r;
        prev_idle_r  <= tick_r[3];
        prev_rx_r    <= rx_r;
        prev_tx_r    <= tx_r;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_r[0] <= in_ticks_user;
      tick_r[1] <= in_ticks_nice;
      tick_r[2] <= in_ticks_system;
      tick_r[3] <= in_ticks_idle;
      if (TICK_COUNTERS > 4)  tick_r[4 % TICK_COUNTERS] <= in_ticks_iowait;
      if (TICK_COUNTERS > 5)  tick_r[5 % TICK_COUNTERS] <= in_ticks_irq;
      if (TICK_COUNTERS > 6)  tick_r[6 % TICK_COUNTERS] <= in_ticks_softirq;
      if (TICK_COUNTERS > 7)  tick_r[7 % TICK_COUNTERS] <= in_ticks_steal;
      if (TICK_COUNTERS > 8)  tick_r[8 % TICK_COUNTERS] <= in_ticks_guest;
      if (TICK_COUNTERS > 9)  tick_r[9 % TICK_COUNTERS] <= in_ticks_guest_nice;
      rx_r  <= in_rx_byte_count;
      tx_r  <= in_tx_byte_count;
      sum_r <= '0;
    end else if (state_r == S_SUM) begin
      sum_r <= sum_r + tick_r[cnt_r];
    end

    if (state_r == S_DELTA) begin
      dt_r <= sum_r - prev_total_r;
      di_r <= tick_r[3] - prev_idle_r;
    end
    if (state_r == S_BUSY) bz_r <= dt_r - di_r;

    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_cpu_r     <= held_cpu_r;
      out_rx_r      <= held_rx_r;
      out_tx_r      <= held_tx_r;
      out_cpu_rep_r <= cpu_rep_r;
      out_rx_rep_r  <= rx_rep_r;
      out_tx_rep_r  <= tx_rep_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cpu_load_pct = out_cpu_r;
  assign out_cpu_report   = out_cpu_rep_r;
  assign out_rx_load_pct  = out_rx_r;
  assign out_rx_report    = out_rx_rep_r;
  assign out_tx_load_pct  = out_tx_r;
  assign out_tx_report    = out_tx_rep_r;

endmodule
